// ----- design/quad_incremental_pid_assert.svh -----
// Assertion macros shared by the quad_incremental_pid RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef QUAD_INCREMENTAL_PID_ASSERT_SVH
`define QUAD_INCREMENTAL_PID_ASSERT_SVH

// Same-cycle implication.
`define QIP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define QIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/qip_pkg.sv -----
// Package for the quad incremental PID speed loop: widths, reset values,
// register indexes and the structs passed between modules. No dependencies.
package qip_pkg;

    localparam int WHEELS         = 4;
    localparam int SPEED_BITS     = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 16;
    localparam int LIMIT_W        = 15;
    localparam int DRIVE_W        = 16;

    localparam int ERR_W  = SPEED_BITS + 1;
    localparam int D1_W   = ERR_W + 1;
    localparam int D2_W   = ERR_W + 2;
    localparam int P_W    = GAIN_W + D2_W;
    localparam int ACC_W  = P_W + 2;
    localparam int INC_W  = ACC_W - GAIN_FRAC_BITS;
    localparam int SUM_W  = INC_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = ((2 * WHEELS * SPEED_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((WHEELS * DRIVE_W + 7) / 8) * 8;

    localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(256);
    localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = '0;
    localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = '0;
    localparam logic [LIMIT_W-1:0]       DRIVE_LIMIT_RST = LIMIT_W'(7000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP   = 2'd0,
        CFG_GAIN_INTEG  = 2'd1,
        CFG_GAIN_DERIV  = 2'd2,
        CFG_DRIVE_LIMIT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [LIMIT_W-1:0]       limit;
    } pid_cfg_t;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ldo;
    } stage_ctl_t;

endpackage

// ----- design/qip_lane.sv -----
// One wheel lane: error history, three gain products, truncating scale and
// the saturating drive accumulator. Depends on qip_pkg and the stage controls.
module qip_lane (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  qip_pkg::pid_cfg_t                      cfg,
    input  qip_pkg::stage_ctl_t                    ctl,
    input  logic signed [qip_pkg::SPEED_BITS-1:0]  target,
    input  logic signed [qip_pkg::SPEED_BITS-1:0]  measured,
    output logic signed [qip_pkg::DRIVE_W-1:0]     drive
);

    localparam int ERR_W = qip_pkg::ERR_W;
    localparam int D1_W  = qip_pkg::D1_W;
    localparam int D2_W  = qip_pkg::D2_W;
    localparam int P_W   = qip_pkg::P_W;
    localparam int ACC_W = qip_pkg::ACC_W;
    localparam int INC_W = qip_pkg::INC_W;
    localparam int SUM_W = qip_pkg::SUM_W;
    localparam logic signed [ACC_W-1:0] FRAC_MASK =
        ACC_W'((64'd1 << qip_pkg::GAIN_FRAC_BITS) - 64'd1);

    logic signed [ERR_W-1:0] e0_reg, e1_reg;
    logic signed [ERR_W-1:0] err_next;
    logic                    en_next;

    logic signed [ERR_W-1:0] e_s1_reg;
    logic signed [D1_W-1:0]  d1_s1_reg, d1_next;
    logic signed [D2_W-1:0]  d2_s1_reg, d2_next;
    logic                    en_s1_reg;

    logic signed [P_W-1:0]   pp_s2_reg, pi_s2_reg, pd_s2_reg;
    logic signed [P_W-1:0]   pp_next, pi_next, pd_next;
    logic                    en_s2_reg;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] bias;
    logic signed [INC_W-1:0] inc_s3_reg, inc_next;
    logic                    en_s3_reg;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lim;
    logic signed [qip_pkg::DRIVE_W-1:0] drive_reg, drive_next;

    assign err_next = ERR_W'(target) - ERR_W'(measured);
    assign en_next  = (target != '0);
    assign d1_next  = D1_W'(err_next) - D1_W'(e0_reg);
    assign d2_next  = D2_W'(err_next) - (D2_W'(e0_reg) <<< 1) + D2_W'(e1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e0_reg <= '0;
            e1_reg <= '0;
        end else if (ctl.ld1 && en_next) begin
            e1_reg <= e0_reg;
            e0_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld1) begin
            e_s1_reg  <= err_next;
            d1_s1_reg <= d1_next;
            d2_s1_reg <= d2_next;
            en_s1_reg <= en_next;
        end
    end

    assign pp_next = P_W'(cfg.kp) * P_W'(d1_s1_reg);
    assign pi_next = P_W'(cfg.ki) * P_W'(e_s1_reg);
    assign pd_next = P_W'(cfg.kd) * P_W'(d2_s1_reg);

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            pp_s2_reg <= pp_next;
            pi_s2_reg <= pi_next;
            pd_s2_reg <= pd_next;
            en_s2_reg <= en_s1_reg;
        end
    end

    // Bias negative sums so the shift truncates toward zero.
    assign acc      = ACC_W'(pp_s2_reg) + ACC_W'(pi_s2_reg) + ACC_W'(pd_s2_reg);
    assign bias     = acc[ACC_W-1] ? FRAC_MASK : '0;
    assign inc_next = INC_W'((acc + bias) >>> qip_pkg::GAIN_FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (ctl.ld3) begin
            inc_s3_reg <= inc_next;
            en_s3_reg  <= en_s2_reg;
        end
    end

    assign sum = SUM_W'(drive_reg) + SUM_W'(inc_s3_reg);
    assign lim = SUM_W'({1'b0, cfg.limit});

    always_comb begin
        drive_next = '0;
        if (en_s3_reg) begin
            priority if (sum > lim) begin
                drive_next = qip_pkg::DRIVE_W'(lim);
            end else if (sum < -lim) begin
                drive_next = qip_pkg::DRIVE_W'(-lim);
            end else begin
                drive_next = qip_pkg::DRIVE_W'(sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= '0;
        end else if (ctl.ldo) begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

// ----- design/qip_ctrl.sv -----
// Pipeline control: valid flags per stage, per-stage ready chain and the
// output valid. Depends on qip_pkg and the assertion macro header.
`include "quad_incremental_pid_assert.svh"

module qip_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output qip_pkg::stage_ctl_t ctl
);

    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy_out;

    // Each stage moves when it is empty or the next one moves.
    assign rdy_out = !vo_reg || m_tready;
    assign rdy3    = !v3_reg || rdy_out;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;

    assign s_tready = rdy1;
    assign m_tvalid = vo_reg;

    always_comb begin
        ctl.ld1 = s_tvalid && rdy1;
        ctl.ld2 = v1_reg && rdy2;
        ctl.ld3 = v2_reg && rdy3;
        ctl.ldo = v3_reg && rdy_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1)    v1_reg <= s_tvalid;
            if (rdy2)    v2_reg <= v1_reg;
            if (rdy3)    v3_reg <= v2_reg;
            if (rdy_out) vo_reg <= v3_reg;
        end
    end

    `QIP_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, v1_reg)
    `QIP_ASSERT_NEXT(a_s3_holds_on_stall, v3_reg && !rdy_out, v3_reg && vo_reg)
    `QIP_ASSERT_NOW(a_out_from_s3, $rose(vo_reg), $past(v3_reg))

endmodule

// ----- design/quad_incremental_pid.sv -----
// Quad incremental PID: four wheel lanes behind one shared stage controller.
// Accepted requests pass the s1, s2, s3 and drive registers to m_tvalid;
// one request per cycle unless m_tready stalls, set by the four-stage lane
// pipeline (error, multiply, scale, accumulate), drive_reg fed back to it.
// Reset (aresetn low, synchronous) clears error history, drive totals,
// pipeline valids and loads the default gains and limit.
module quad_incremental_pid (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [qip_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qip_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // target_a, target_b, target_c, target_d, measured_a .. measured_d
    input  logic [qip_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // drive_a, drive_b, drive_c, drive_d
    output logic [qip_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int WHEELS = qip_pkg::WHEELS;
    localparam int SB     = qip_pkg::SPEED_BITS;
    localparam int DW     = qip_pkg::DRIVE_W;

    qip_pkg::pid_cfg_t   cfg_reg;
    qip_pkg::stage_ctl_t ctl;
    logic [WHEELS*DW-1:0] drive_flat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp    <= qip_pkg::GAIN_PROP_RST;
            cfg_reg.ki    <= qip_pkg::GAIN_INTEG_RST;
            cfg_reg.kd    <= qip_pkg::GAIN_DERIV_RST;
            cfg_reg.limit <= qip_pkg::DRIVE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (qip_pkg::cfg_index_t'(cfg_index))
                qip_pkg::CFG_GAIN_PROP:   cfg_reg.kp    <= cfg_wdata[qip_pkg::GAIN_W-1:0];
                qip_pkg::CFG_GAIN_INTEG:  cfg_reg.ki    <= cfg_wdata[qip_pkg::GAIN_W-1:0];
                qip_pkg::CFG_GAIN_DERIV:  cfg_reg.kd    <= cfg_wdata[qip_pkg::GAIN_W-1:0];
                qip_pkg::CFG_DRIVE_LIMIT: cfg_reg.limit <= cfg_wdata[qip_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    qip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    for (genvar w = 0; w < WHEELS; w++) begin : g_lane
        qip_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cfg      (cfg_reg),
            .ctl      (ctl),
            .target   (s_tdata[w*SB +: SB]),
            .measured (s_tdata[(WHEELS+w)*SB +: SB]),
            .drive    (drive_flat[w*DW +: DW])
        );
    end

    assign m_tdata = qip_pkg::M_DATA_W'(drive_flat);

endmodule
